/* rtl/vcs_pkg.sv */
`default_nettype none
package vcs_pkg;

    localparam int VEL_W = 24;
    localparam int CFG_W = 23;
    localparam int DB_W  = 16;

    // Divisor of the unscaled translation path: sticks are in percent.
    localparam logic [31:0] PERCENT_DEN = 32'd100;
    // Squared stick length above which the translation target is rescaled.
    localparam logic [15:0] STICK_LIMIT_SQ = 16'd10000;

    localparam logic [2:0] CFG_SPEED_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_ACCEL_STEP     = 3'd1;
    localparam logic [2:0] CFG_MAX_ROT_SPEED  = 3'd2;
    localparam logic [2:0] CFG_ROT_ACCEL_STEP = 3'd3;
    localparam logic [2:0] CFG_ROT_DEADBAND   = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] speed_limit;
        logic [CFG_W-1:0] accel_step;
        logic [CFG_W-1:0] max_rot_speed;
        logic [CFG_W-1:0] rot_accel_step;
        logic [DB_W-1:0]  rot_deadband;
    } vcs_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_TX, ST_MUL_TY, ST_SQRT_T, ST_WAIT_ST,
        ST_DIV_TX, ST_WAIT_TX, ST_DIV_TY, ST_WAIT_TY,
        ST_ROT_MUL, ST_SQRT_R, ST_WAIT_SR, ST_DIV_R, ST_WAIT_R,
        ST_DIFF, ST_SQA, ST_SQB, ST_ACC, ST_CHK, ST_NORM,
        ST_SQRT_M, ST_WAIT_M, ST_MUL_A, ST_DIV_A, ST_WAIT_A,
        ST_MUL_B, ST_DIV_B, ST_WAIT_B, ST_ROT_SLEW, ST_DONE
    } vcs_state_t;

    function automatic logic signed [39:0] apply_sign(input logic neg, input logic [31:0] mag);
        logic signed [39:0] v;
        v = $signed({8'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd8388607;
        lo = -40'sd8388608;
        if (v > hi) begin
            return hi[VEL_W-1:0];
        end else if (v < lo) begin
            return lo[VEL_W-1:0];
        end
        return v[VEL_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/velocity_command_shaper_unit.sv */
`default_nettype none
// Velocity command shaper: turns joystick ticks into slew-limited velocity commands.
// The slave stream carries one control tick per transaction: translation stick x/y and
// rotation stick x/y in percent. The master stream returns one transaction per tick with
// the commanded vel_x, vel_y and vel_rot, signed fixed point with 8 fraction bits.
// A separate configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// five limit registers; it is always ready and should be used while the block is idle.
// The time that a tick takes is set by one iterative square-root unit and one iterative
// divider, called up to three and five times under a small sequencer, plus a normalizing
// shift of one bit per cycle and a check step for a small velocity error.
// s_tready is high only while the sequencer is idle, so one tick is in work at a time and
// a new tick is accepted only once the last has left the sequencer. The result sits in an
// output register; the next tick may be accepted while it waits. If the receiver stalls,
// a finished tick waits in the sequencer until the register frees, and no result is lost.
// Synchronous active-low reset clears the velocity state to zero, restores the default
// limits and drops m_tvalid.
module velocity_command_shaper_unit
    import vcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] trans_stick_x, [15:8] trans_stick_y, [23:16] rot_stick_x, [31:24] rot_stick_y
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [23:0] vel_x, [47:24] vel_y, [71:48] vel_rot
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    vcs_cfg_t cfg_reg;
    logic     m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic     core_idle, core_done, out_free;
    logic [VEL_W-1:0] vel_x, vel_y, vel_rot;

    // Registers are masked to their widths; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit    <= 23'd65536;
            cfg_reg.accel_step     <= 23'd1024;
            cfg_reg.max_rot_speed  <= 23'd4096;
            cfg_reg.rot_accel_step <= 23'd128;
            cfg_reg.rot_deadband   <= 16'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SPEED_LIMIT:    cfg_reg.speed_limit    <= cfg_data[CFG_W-1:0];
                CFG_ACCEL_STEP:     cfg_reg.accel_step     <= cfg_data[CFG_W-1:0];
                CFG_MAX_ROT_SPEED:  cfg_reg.max_rot_speed  <= cfg_data[CFG_W-1:0];
                CFG_ROT_ACCEL_STEP: cfg_reg.rot_accel_step <= cfg_data[CFG_W-1:0];
                CFG_ROT_DEADBAND:   cfg_reg.rot_deadband   <= cfg_data[DB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = core_idle;

    vcs_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && core_idle),
        .stick_x  (s_tdata[7:0]),
        .stick_y  (s_tdata[15:8]),
        .rot_x    (s_tdata[23:16]),
        .rot_y    (s_tdata[31:24]),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .idle     (core_idle),
        .done     (core_done),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .vel_rot  (vel_rot)
    );

    // Output register: loaded when a tick finishes, held while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (core_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (core_done) begin
            m_tdata_reg <= {vel_rot, vel_y, vel_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* rtl/vcs_sqrt.sv */
`default_nettype none
module vcs_sqrt
    import vcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] operand,
    output logic             done,
    output logic [31:0]      root
);

    // Bit-by-bit integer square root, one result bit per cycle.
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start) begin
            v_next    = operand;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
    end

    assign root = r_next[31:0];

endmodule
`default_nettype wire

/* rtl/vcs_div.sv */
`default_nettype none
module vcs_div
    import vcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [55:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quot
);

    // Restoring divider; the quotient must fit in 32 bits, so the upper
    // numerator bits are already below the divisor and load as the remainder.
    logic [31:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    assign trial = {rem_reg, low_reg[31]};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start) begin
            rem_next  = {8'b0, num[55:32]};
            low_next  = num[31:0];
            den_next  = den;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = 32'(trial - {1'b0, den_reg});
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            low_next = {low_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign quot = q_next;

endmodule
`default_nettype wire

/* rtl/vcs_core.sv */
`default_nettype none
module vcs_core
    import vcs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [7:0]       stick_x,
    input  wire logic [7:0]       stick_y,
    input  wire logic [7:0]       rot_x,
    input  wire logic [7:0]       rot_y,
    input  wire vcs_cfg_t         cfg,
    input  wire logic             out_free,
    output logic                  idle,
    output logic                  done,
    output logic [VEL_W-1:0]      vel_x,
    output logic [VEL_W-1:0]      vel_y,
    output logic [VEL_W-1:0]      vel_rot
);

    vcs_state_t state_reg, state_next;

    logic [7:0]  ax_reg, ay_reg, arx_reg;
    logic        sx_reg, sy_reg, srx_reg;
    logic [15:0] s_reg, sr_reg;
    logic [55:0] num_reg;
    logic [31:0] den_reg;
    logic [VEL_W-1:0] tx_reg, ty_reg, tr_reg;
    logic [VEL_W-1:0] cur_x_reg, cur_y_reg, cur_r_reg;
    logic [31:0] a_reg, b_reg;
    logic        ngx_reg, ngy_reg, normed_reg;
    logic [63:0] sqa_reg, sqb_reg, acc2_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        sqrt_start, sqrt_done, div_start, div_done;
    logic [63:0] sqrt_in;
    logic [31:0] root, quot;
    logic [55:0] div_num;
    logic [63:0] sq_sum;

    logic [7:0]  in_ax, in_ay, in_arx, in_ary;
    logic [24:0] dx, dy, dr, dr_abs;
    logic [24:0] dx_abs, dy_abs;

    assign in_ax  = stick_x[7] ? 8'(-stick_x) : stick_x;
    assign in_ay  = stick_y[7] ? 8'(-stick_y) : stick_y;
    assign in_arx = rot_x[7] ? 8'(-rot_x) : rot_x;
    assign in_ary = rot_y[7] ? 8'(-rot_y) : rot_y;

    assign sq_sum  = sqa_reg + sqb_reg;
    assign div_num = num_reg + {24'b0, 1'b0, den_reg[31:1]};
    assign prod    = {32'b0, mul_a} * {32'b0, mul_b};

    assign dx     = {tx_reg[VEL_W-1], tx_reg} - {cur_x_reg[VEL_W-1], cur_x_reg};
    assign dy     = {ty_reg[VEL_W-1], ty_reg} - {cur_y_reg[VEL_W-1], cur_y_reg};
    assign dx_abs = dx[24] ? -dx : dx;
    assign dy_abs = dy[24] ? -dy : dy;
    assign dr     = {tr_reg[VEL_W-1], tr_reg} - {cur_r_reg[VEL_W-1], cur_r_reg};
    assign dr_abs = dr[24] ? -dr : dr;

    vcs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (sqrt_in),
        .done    (sqrt_done),
        .root    (root)
    );

    vcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        sqrt_in    = '0;
        mul_a      = '0;
        mul_b      = '0;
        idle       = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    state_next = ST_MUL_TX;
                end
            end
            ST_MUL_TX: begin
                mul_a = {9'b0, cfg.speed_limit};
                mul_b = {24'b0, ax_reg};
                state_next = ST_MUL_TY;
            end
            ST_MUL_TY: begin
                mul_a = {9'b0, cfg.speed_limit};
                mul_b = {24'b0, ay_reg};
                state_next = (s_reg > STICK_LIMIT_SQ) ? ST_SQRT_T : ST_DIV_TX;
            end
            ST_SQRT_T: begin
                sqrt_start = 1'b1;
                sqrt_in    = {16'b0, s_reg, 32'b0};
                state_next = ST_WAIT_ST;
            end
            ST_WAIT_ST: begin
                if (sqrt_done) begin
                    state_next = ST_DIV_TX;
                end
            end
            ST_DIV_TX: begin
                div_start  = 1'b1;
                state_next = ST_WAIT_TX;
            end
            ST_WAIT_TX: begin
                if (div_done) begin
                    state_next = ST_DIV_TY;
                end
            end
            ST_DIV_TY: begin
                div_start  = 1'b1;
                state_next = ST_WAIT_TY;
            end
            ST_WAIT_TY: begin
                if (div_done) begin
                    state_next = ST_ROT_MUL;
                end
            end
            ST_ROT_MUL: begin
                mul_a = {9'b0, cfg.max_rot_speed};
                mul_b = {24'b0, arx_reg};
                state_next = (sr_reg == 16'd0) ? ST_DIFF : ST_SQRT_R;
            end
            ST_SQRT_R: begin
                sqrt_start = 1'b1;
                sqrt_in    = {16'b0, sr_reg, 32'b0};
                state_next = ST_WAIT_SR;
            end
            ST_WAIT_SR: begin
                if (sqrt_done) begin
                    state_next = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                div_start  = 1'b1;
                state_next = ST_WAIT_R;
            end
            ST_WAIT_R: begin
                if (div_done) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                if (dx_abs < 25'h80_0000 && dy_abs < 25'h80_0000) begin
                    state_next = ST_SQA;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_SQA: begin
                mul_a = a_reg;
                mul_b = a_reg;
                state_next = ST_SQB;
            end
            ST_SQB: begin
                mul_a = b_reg;
                mul_b = b_reg;
                state_next = normed_reg ? ST_SQRT_M : ST_ACC;
            end
            ST_ACC: begin
                mul_a = {9'b0, cfg.accel_step};
                mul_b = {9'b0, cfg.accel_step};
                state_next = ST_CHK;
            end
            ST_CHK: begin
                state_next = (sq_sum <= acc2_reg) ? ST_ROT_SLEW : ST_NORM;
            end
            ST_NORM: begin
                if ((a_reg[31:30] | b_reg[31:30]) != 2'b00) begin
                    state_next = ST_SQA;
                end
            end
            ST_SQRT_M: begin
                sqrt_start = 1'b1;
                sqrt_in    = sq_sum;
                state_next = ST_WAIT_M;
            end
            ST_WAIT_M: begin
                if (sqrt_done) begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                mul_a = {9'b0, cfg.accel_step};
                mul_b = a_reg;
                state_next = ST_DIV_A;
            end
            ST_DIV_A: begin
                div_start  = 1'b1;
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A: begin
                if (div_done) begin
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                mul_a = {9'b0, cfg.accel_step};
                mul_b = b_reg;
                state_next = ST_DIV_B;
            end
            ST_DIV_B: begin
                div_start  = 1'b1;
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B: begin
                if (div_done) begin
                    state_next = ST_ROT_SLEW;
                end
            end
            ST_ROT_SLEW: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Velocity state resets to zero; the working registers need no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_r_reg <= '0;
        end else begin
            case (state_reg)
                ST_CHK: begin
                    if (sq_sum <= acc2_reg) begin
                        cur_x_reg <= tx_reg;
                        cur_y_reg <= ty_reg;
                    end
                end
                ST_WAIT_A: begin
                    if (div_done) begin
                        cur_x_reg <= sat_vel(40'($signed(cur_x_reg)) + apply_sign(ngx_reg, quot));
                    end
                end
                ST_WAIT_B: begin
                    if (div_done) begin
                        cur_y_reg <= sat_vel(40'($signed(cur_y_reg)) + apply_sign(ngy_reg, quot));
                    end
                end
                ST_ROT_SLEW: begin
                    if (dr_abs > {2'b0, cfg.rot_accel_step}) begin
                        cur_r_reg <= sat_vel(40'($signed(cur_r_reg))
                                     + apply_sign(dr[24], {9'b0, cfg.rot_accel_step}));
                    end else begin
                        cur_r_reg <= tr_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ax_reg  <= in_ax;
                sx_reg  <= stick_x[7];
                // The vertical translation axis is inverted.
                ay_reg  <= in_ay;
                sy_reg  <= (stick_y != 8'd0) && !stick_y[7];
                arx_reg <= in_arx;
                srx_reg <= rot_x[7];
                s_reg   <= 16'({8'b0, in_ax} * {8'b0, in_ax} + {8'b0, in_ay} * {8'b0, in_ay});
                sr_reg  <= 16'({8'b0, in_arx} * {8'b0, in_arx}
                               + {8'b0, in_ary} * {8'b0, in_ary});
                den_reg <= PERCENT_DEN;
            end
            ST_MUL_TX: begin
                num_reg <= prod[55:0];
            end
            ST_MUL_TY: begin
                sqa_reg <= prod;
            end
            ST_WAIT_ST: begin
                if (sqrt_done) begin
                    den_reg <= root;
                    num_reg <= {num_reg[39:0], 16'b0};
                    sqa_reg <= {sqa_reg[47:0], 16'b0};
                end
            end
            ST_WAIT_TX: begin
                if (div_done) begin
                    tx_reg  <= sat_vel(apply_sign(sx_reg, quot));
                    num_reg <= sqa_reg[55:0];
                end
            end
            ST_WAIT_TY: begin
                if (div_done) begin
                    ty_reg <= sat_vel(apply_sign(sy_reg, quot));
                    tr_reg <= '0;
                end
            end
            ST_ROT_MUL: begin
                num_reg <= prod[55:0];
            end
            ST_WAIT_SR: begin
                if (sqrt_done) begin
                    den_reg <= root;
                    num_reg <= {num_reg[39:0], 16'b0};
                end
            end
            ST_WAIT_R: begin
                if (div_done) begin
                    if (quot < {16'b0, cfg.rot_deadband}) begin
                        tr_reg <= '0;
                    end else begin
                        tr_reg <= sat_vel(apply_sign(srx_reg, quot));
                    end
                end
            end
            ST_DIFF: begin
                a_reg      <= {7'b0, dx_abs};
                b_reg      <= {7'b0, dy_abs};
                ngx_reg    <= dx[24];
                ngy_reg    <= dy[24];
                normed_reg <= 1'b0;
            end
            ST_SQA: begin
                sqa_reg <= prod;
            end
            ST_SQB: begin
                sqb_reg <= prod;
            end
            ST_ACC: begin
                acc2_reg <= prod;
            end
            ST_NORM: begin
                if ((a_reg[31:30] | b_reg[31:30]) == 2'b00) begin
                    a_reg <= {a_reg[30:0], 1'b0};
                    b_reg <= {b_reg[30:0], 1'b0};
                end else begin
                    normed_reg <= 1'b1;
                end
            end
            ST_WAIT_M: begin
                if (sqrt_done) begin
                    den_reg <= root;
                end
            end
            ST_MUL_A: begin
                num_reg <= prod[55:0];
            end
            ST_MUL_B: begin
                num_reg <= prod[55:0];
            end
            default: begin
            end
        endcase
    end

    assign vel_x   = cur_x_reg;
    assign vel_y   = cur_y_reg;
    assign vel_rot = cur_r_reg;

endmodule
`default_nettype wire

/* rtl/vcs_checker.sv */
`default_nettype none
module vcs_checker
    import vcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata
);

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Once a tick is taken the block is busy on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second tick taken back to back");

    // A new result only appears at the end of a busy period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

endmodule

bind velocity_command_shaper_unit vcs_checker u_vcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
    import vcs_pkg::*;

    // Register index outside the five defined limits; the block must ignore it.
    localparam logic [2:0] CFG_SPARE_IDX = 3'd6;
    localparam int         CLK_HALF      = 6;
    // This covers the drain at the end.
    localparam int         DRAIN_CYCLES  = 400;
    localparam int         PHASES        = 9;
    localparam int         TICKS_PER_PH  = 165;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_rot;
    } vel_cmd_t;

    typedef struct {
        byte      tx;
        byte      ty;
        byte      rx;
        byte      ry;
        bit       known;
        vel_cmd_t cmd;
    } stick_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [71:0]       m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [31:0]       cfg_data  = '0;

    // Local copy of the limit registers and the velocity state.
    longint unsigned   lim_speed, lim_accel, lim_rot_speed, lim_rot_accel, lim_deadband;
    longint            vel_x_q, vel_y_q, vel_rot_q;

    vel_cmd_t          pending_cmds[$];
    int                error_count  = 0;
    int                stall_cycles = 0;
    bit                no_gaps      = 1'b0;

    velocity_command_shaper_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    // Hard stop in case the block hangs somewhere.
    initial begin
        #(2 * CLK_HALF * 3000000);
        $display("tb: done, errors");
        $finish;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Division rounded to nearest, ties away from zero.
    function automatic longint div_round(input longint n, input longint unsigned d);
        longint unsigned q;
        q = (mag(n) + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // k * v / |stick|, the length carried with 16 fraction bits.
    function automatic longint along_dir(input longint unsigned k, input longint v,
                                         input longint s);
        longint unsigned r;
        r = root_floor(longint'(s) << 32);
        return div_round(longint'(k) * v * 65536, r);
    endfunction

    function automatic longint clip_vel(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // One control tick: targets from the sticks, then the slew-limited update.
    function automatic vel_cmd_t shape_tick(input byte tx_in, input byte ty_in,
                                            input byte rx_in, input byte ry_in);
        longint x, y, rx, ry, s, sr, tgt_x, tgt_y, tgt_r, dx, dy, dr;
        longint unsigned a, b, mx, m, ma, mb;
        bit snap;
        vel_cmd_t cmd;
        x = tx_in;
        y = -longint'(ty_in);
        rx = rx_in;
        ry = ry_in;
        s = x * x + y * y;
        sr = rx * rx + ry * ry;
        if (s > 10000) begin
            tgt_x = along_dir(lim_speed, x, s);
            tgt_y = along_dir(lim_speed, y, s);
        end else begin
            tgt_x = div_round(longint'(lim_speed) * x, 100);
            tgt_y = div_round(longint'(lim_speed) * y, 100);
        end
        tgt_x = clip_vel(tgt_x);
        tgt_y = clip_vel(tgt_y);
        tgt_r = (sr == 0) ? 0 : along_dir(lim_rot_speed, rx, sr);
        if (mag(tgt_r) < lim_deadband) tgt_r = 0;
        tgt_r = clip_vel(tgt_r);

        dx = tgt_x - vel_x_q;
        dy = tgt_y - vel_y_q;
        a = mag(dx);
        b = mag(dy);
        mx = (a > b) ? a : b;
        snap = 1'b0;
        if (mx < (64'd1 << 23)) snap = (a * a + b * b) <= lim_accel * lim_accel;
        if (snap) begin
            vel_x_q = tgt_x;
            vel_y_q = tgt_y;
        end else begin
            // Normalize so the larger error component sits in [2^30, 2^31).
            while (mx >= (64'd1 << 31)) begin
                a >>= 1; b >>= 1; mx >>= 1;
            end
            while (mx < (64'd1 << 30)) begin
                a <<= 1; b <<= 1; mx <<= 1;
            end
            m = root_floor(a * a + b * b);
            ma = (lim_accel * a + m / 2) / m;
            mb = (lim_accel * b + m / 2) / m;
            vel_x_q = clip_vel(vel_x_q + ((dx < 0) ? -longint'(ma) : longint'(ma)));
            vel_y_q = clip_vel(vel_y_q + ((dy < 0) ? -longint'(mb) : longint'(mb)));
        end

        dr = tgt_r - vel_rot_q;
        if (mag(dr) > lim_rot_accel)
            vel_rot_q = clip_vel(vel_rot_q + ((dr < 0) ? -longint'(lim_rot_accel)
                                                       : longint'(lim_rot_accel)));
        else
            vel_rot_q = tgt_r;

        cmd.vel_x = vel_x_q[VEL_W-1:0];
        cmd.vel_y = vel_y_q[VEL_W-1:0];
        cmd.vel_rot = vel_rot_q[VEL_W-1:0];
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb: %0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Configuration write; the local copy follows at the accepting edge.
    task automatic write_limit(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SPEED_LIMIT:    lim_speed     = value[CFG_W-1:0];
            CFG_ACCEL_STEP:     lim_accel     = value[CFG_W-1:0];
            CFG_MAX_ROT_SPEED:  lim_rot_speed = value[CFG_W-1:0];
            CFG_ROT_ACCEL_STEP: lim_rot_accel = value[CFG_W-1:0];
            CFG_ROT_DEADBAND:   lim_deadband  = value[DB_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offers one tick starting at a falling edge and returns at the falling edge
    // after the transaction. The valid stays high when the next tick follows at once.
    task automatic send_tick(input byte tx, input byte ty, input byte rx, input byte ry,
                             input bit known, input vel_cmd_t cmd);
        vel_cmd_t predicted;
        if (!no_gaps && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ry, rx, ty, tx};
        do @(posedge aclk); while (!s_tready);
        predicted = shape_tick(tx, ty, rx, ry);
        if (known) begin
            if (predicted.vel_x != cmd.vel_x)
                report_mismatch("hand-computed vel_x", predicted.vel_x, cmd.vel_x);
            if (predicted.vel_y != cmd.vel_y)
                report_mismatch("hand-computed vel_y", predicted.vel_y, cmd.vel_y);
            if (predicted.vel_rot != cmd.vel_rot)
                report_mismatch("hand-computed vel_rot", predicted.vel_rot, cmd.vel_rot);
        end
        pending_cmds.push_back(predicted);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic byte random_stick();
        if ($urandom_range(99) < 12) return byte'($urandom_range(255));
        if ($urandom_range(99) < 10) return 8'sd0;
        return byte'(int'($urandom_range(200)) - 100);
    endfunction

    function automatic logic [31:0] random_limit(input int phase, input int sel);
        case (phase)
            1: return 32'hFFFF_FFFF;                      // every limit at its maximum
            2: return 32'h0;                              // every limit zero
            3: return (sel == 0 || sel == 2) ? 32'd300 : 32'h7F_FFFF;
            default: begin
                case ($urandom_range(3))
                    0: return $urandom;
                    1: return $urandom_range(2000);
                    default: return $urandom_range(200000);
                endcase
            end
        endcase
    endfunction

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    always @(negedge aclk) begin
        if (stall_cycles > 0) begin
            m_tready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else if (no_gaps) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 34);
        end
    end

    // Result checker, sampled at the rising edge.
    always @(posedge aclk) begin
        vel_cmd_t got;
        vel_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.vel_x = m_tdata[23:0];
            got.vel_y = m_tdata[47:24];
            got.vel_rot = m_tdata[71:48];
            if (pending_cmds.size() == 0) begin
                report_mismatch("unexpected result transaction, vel_x", got.vel_x, 0);
            end else begin
                want = pending_cmds.pop_front();
                if (got.vel_x != want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
                if (got.vel_y != want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
                if (got.vel_rot != want.vel_rot)
                    report_mismatch("vel_rot", got.vel_rot, want.vel_rot);
            end
        end
    end

    // Directed ticks under the reset limits. The first two rows are worked by hand:
    // full right from rest moves x by one accel step, then centered sticks snap back.
    stick_row_t directed_ticks[16] = '{
        '{8'sd100,  8'sd0,    8'sd0,    8'sd0,    1'b1, '{24'sd1024, 24'sd0, 24'sd0}},
        '{8'sd0,    8'sd0,    8'sd0,    8'sd0,    1'b1, '{24'sd0, 24'sd0, 24'sd0}},
        '{-8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd127,  8'sd127,  8'sd127,  8'sd127,  1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{-8'sd100, 8'sd100,  8'sd0,    8'sd100,  1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd0,    -8'sd100, 8'sd100,  8'sd0,    1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd0,    8'sd0,    -8'sd100, 8'sd0,    1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd70,   8'sd70,   8'sd1,    8'sd127,  1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd71,   -8'sd71,  8'sd1,    -8'sd128, 1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd100,  8'sd100,  8'sd0,    -8'sd100, 1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd1,    8'sd0,    8'sd50,   8'sd50,   1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{-8'sd1,   8'sd1,    -8'sd50,  8'sd50,   1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd0,    8'sd0,    8'sd0,    8'sd0,    1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd0,    8'sd0,    8'sd0,    8'sd0,    1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{8'sd85,   -8'sd85,  -8'sd128, 8'sd127,  1'b0, '{24'sd0, 24'sd0, 24'sd0}},
        '{-8'sd85,  8'sd85,   8'sd127,  -8'sd128, 1'b0, '{24'sd0, 24'sd0, 24'sd0}}
    };

    initial begin
        byte tx, ty, rx, ry;
        int  run_len;
        int  sent;
        vel_cmd_t none;
        none = '0;
        lim_speed = 65536; lim_accel = 1024; lim_rot_speed = 4096;
        lim_rot_accel = 128; lim_deadband = 3;
        vel_x_q = 0; vel_y_q = 0; vel_rot_q = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_ticks[i]) begin
            send_tick(directed_ticks[i].tx, directed_ticks[i].ty, directed_ticks[i].rx,
                      directed_ticks[i].ry, directed_ticks[i].known, directed_ticks[i].cmd);
        end
        wait_idle();

        for (int phase = 1; phase < PHASES; phase++) begin
            write_limit(CFG_SPEED_LIMIT,    random_limit(phase, 0));
            write_limit(CFG_ACCEL_STEP,     random_limit(phase, 1));
            write_limit(CFG_MAX_ROT_SPEED,  random_limit(phase, 2));
            write_limit(CFG_ROT_ACCEL_STEP, random_limit(phase, 3));
            write_limit(CFG_ROT_DEADBAND,   (phase == 6) ? 32'd65535 : random_limit(phase, 4));
            write_limit(CFG_SPARE_IDX,      $urandom);
            no_gaps = (phase == 4);
            sent = 0;
            while (sent < TICKS_PER_PH) begin
                // Hold a stick position for a while so the velocity can settle.
                tx = random_stick(); ty = random_stick();
                rx = random_stick(); ry = random_stick();
                run_len = ($urandom_range(99) < 25) ? 1 : $urandom_range(40, 2);
                for (int k = 0; k < run_len && sent < TICKS_PER_PH; k++) begin
                    if (phase == 5 && sent == 20) stall_cycles = 2500;
                    send_tick(tx, ty, rx, ry, 1'b0, none);
                    sent++;
                end
            end
            no_gaps = 1'b0;
            wait_idle();
        end

        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
